// ===== rtl/core/cas_pkg.sv =====
// shared types, codes and calendar helpers for the clock and alarm set controller
`timescale 1ns / 1ps
package cas_pkg;

  typedef enum logic [1:0] {
    ACT_MODE = 2'd0,
    ACT_SET  = 2'd1,
    ACT_INC  = 2'd2,
    ACT_LOAD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VIEW_TIME  = 2'd0,
    VIEW_DATE  = 2'd1,
    VIEW_LUNAR = 2'd2,
    VIEW_ALARM = 2'd3
  } view_t;

  // edit field positions, meaning depends on the view
  localparam logic [2:0] EDIT_NONE = 3'd0;
  localparam logic [2:0] EDIT_1    = 3'd1;
  localparam logic [2:0] EDIT_2    = 3'd2;
  localparam logic [2:0] EDIT_3    = 3'd3;
  localparam logic [2:0] EDIT_4    = 3'd4;

  localparam logic [2:0] TIME_LAST  = EDIT_4;
  localparam logic [2:0] DATE_LAST  = EDIT_3;
  localparam logic [2:0] ALARM_LAST = EDIT_2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [4:0] HOUR_RST   = 5'd11;
  localparam logic [5:0] MINUTE_RST = 6'd50;
  localparam logic [4:0] DATE_RST   = 5'd25;
  localparam logic [3:0] MONTH_RST  = 4'd12;
  localparam logic [6:0] YEAR_RST   = 7'd21;

  typedef struct packed {
    view_t      view;
    logic [2:0] edit;
    logic       armed;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
  } cas_state_t;

  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] date;
    logic [7:0] hour;
    logic [7:0] minute;
  } cas_bcd_t;

  // invalid digits still decode as high*10+low
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] hi_x10;
    hi_x10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
    return hi_x10 + {4'b0000, b[3:0]};
  endfunction

  // months outside 1..12 take the february length
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] d;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      default: d = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/cas_update.sv =====
// next state of the controller for one button or rtc transaction
`timescale 1ns / 1ps
module cas_update
  import cas_pkg::*;
(
  input  action_t    action,
  input  cas_bcd_t   bcd,
  input  cas_state_t cur,
  output cas_state_t nxt,
  output logic       rtc_write,
  output logic       alarm_hit
);

  logic [5:0] date_inc;
  logic [4:0] month_inc;
  logic [5:0] hour_inc;
  logic [6:0] minute_inc;
  logic [7:0] year_inc;
  logic [5:0] ahour_inc;
  logic [6:0] aminute_inc;
  logic [4:0] dim;
  logic [7:0] bin_minute, bin_hour, bin_date, bin_month, bin_year;

  always_comb begin
    dim = days_in_month(cur.month, cur.year);

    date_inc = {1'b0, cur.date} + 6'd1;
    if (date_inc > {1'b0, dim}) date_inc = 6'd1;
    month_inc = {1'b0, cur.month} + 5'd1;
    if (month_inc > 5'd12) month_inc = 5'd1;
    hour_inc = {1'b0, cur.hour} + 6'd1;
    if (hour_inc > 6'd23) hour_inc = 6'd0;
    minute_inc = {1'b0, cur.minute} + 7'd1;
    if (minute_inc > 7'd59) minute_inc = 7'd0;
    year_inc = {1'b0, cur.year} + 8'd1;
    if (year_inc > 8'd99) year_inc = 8'd0;
    ahour_inc = {1'b0, cur.alarm_hour} + 6'd1;
    if (ahour_inc > 6'd23) ahour_inc = 6'd0;
    aminute_inc = {1'b0, cur.alarm_minute} + 7'd1;
    if (aminute_inc > 7'd59) aminute_inc = 7'd0;

    bin_minute = bcd_to_bin(bcd.minute);
    bin_hour   = bcd_to_bin({2'b00, bcd.hour[5:0]});
    bin_date   = bcd_to_bin(bcd.date);
    bin_month  = bcd_to_bin(bcd.month);
    bin_year   = bcd_to_bin(bcd.year);
  end

  always_comb begin
    nxt       = cur;
    rtc_write = 1'b0;
    unique case (action)
      ACT_MODE: begin
        if (cur.edit == EDIT_NONE) begin
          nxt.view = view_t'(2'(cur.view + 2'd1));
        end else begin
          if (cur.view == VIEW_TIME || cur.view == VIEW_DATE) rtc_write = 1'b1;
          else if (cur.view == VIEW_ALARM) nxt.armed = 1'b1;
          nxt.edit = EDIT_NONE;
        end
      end
      ACT_SET: begin
        case (cur.view)
          VIEW_TIME: nxt.edit = (cur.edit >= TIME_LAST) ? EDIT_NONE : cur.edit + 3'd1;
          VIEW_DATE: nxt.edit = (cur.edit >= DATE_LAST) ? EDIT_NONE : cur.edit + 3'd1;
          VIEW_ALARM: begin
            // stepping past the last alarm field drops the alarm
            if (cur.edit >= ALARM_LAST) begin
              nxt.edit         = EDIT_NONE;
              nxt.alarm_hour   = '0;
              nxt.alarm_minute = '0;
              nxt.armed        = 1'b0;
            end else begin
              nxt.edit = cur.edit + 3'd1;
            end
          end
          default: ;
        endcase
      end
      ACT_INC: begin
        if (cur.edit == EDIT_NONE) begin
          nxt.armed = 1'b0;
        end else if (cur.view == VIEW_TIME || cur.view == VIEW_DATE) begin
          if (cur.edit == EDIT_1) nxt.date = date_inc[4:0];
          else if (cur.edit == EDIT_2) nxt.month = month_inc[3:0];
          else if (cur.edit == EDIT_3 && cur.view == VIEW_TIME) nxt.hour = hour_inc[4:0];
          else if (cur.edit == EDIT_4 && cur.view == VIEW_TIME) nxt.minute = minute_inc[5:0];
          else if (cur.edit == EDIT_3 && cur.view == VIEW_DATE) nxt.year = year_inc[6:0];
        end else if (cur.view == VIEW_ALARM) begin
          if (cur.edit == EDIT_1) nxt.alarm_hour = ahour_inc[4:0];
          else if (cur.edit == EDIT_2) nxt.alarm_minute = aminute_inc[5:0];
        end
      end
      ACT_LOAD: begin
        if (cur.edit == EDIT_NONE) begin
          nxt.minute = bin_minute[5:0];
          nxt.hour   = bin_hour[4:0];
          nxt.date   = bin_date[4:0];
          nxt.month  = bin_month[3:0];
          nxt.year   = bin_year[6:0];
        end
      end
      default: ;
    endcase
    alarm_hit = nxt.armed && (nxt.hour == nxt.alarm_hour) &&
                (nxt.minute == nxt.alarm_minute);
  end

endmodule

// ===== rtl/core/clock_alarm_set_controller.sv =====
// top level of the clock, calendar and alarm set controller
//
//  channel | dir | signals                          | content
//  in_     | in  | tvalid tready tdata[39:0] tuser  | button or rtc load event
//  out_    | out | tvalid tready tdata[47:0]        | state after the event
//
//  one transaction in, one out; a new transaction can be taken every cycle while the output is not stalled
//  each transaction passes the input register, then the state and result register
//  the state update loop closes combinationally through cas_update into the state register
//  rst_n (synchronous, active low) clears both valid flags and loads the reset time
//  a stalled output holds; while the result waits the input register accepts only if it is empty
`timescale 1ns / 1ps
module clock_alarm_set_controller
  import cas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // bcd_minute, bcd_hour, bcd_date, bcd_month, bcd_year (8 bits each)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // view, edit_field, alarm_on, alarm_hit, rtc_write, hour_now, minute_now,
  // date_now, month_now, year_now, alarm_hour_now, alarm_minute_now, 2 zero bits
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  in_vld_r;
  action_t               in_act_r;
  cas_bcd_t              in_bcd_r;
  cas_state_t            st_r, st_nxt;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  rtc_write, alarm_hit;
  logic                  advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  cas_update u_update (
    .action    (in_act_r),
    .bcd       (in_bcd_r),
    .cur       (st_r),
    .nxt       (st_nxt),
    .rtc_write (rtc_write),
    .alarm_hit (alarm_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_act_r <= action_t'(in_tuser);
      in_bcd_r <= cas_bcd_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.view         <= VIEW_TIME;
      st_r.edit         <= EDIT_NONE;
      st_r.armed        <= 1'b0;
      st_r.hour         <= HOUR_RST;
      st_r.minute       <= MINUTE_RST;
      st_r.date         <= DATE_RST;
      st_r.month        <= MONTH_RST;
      st_r.year         <= YEAR_RST;
      st_r.alarm_hour   <= '0;
      st_r.alarm_minute <= '0;
      out_vld_r         <= 1'b0;
    end else if (advance) begin
      st_r      <= st_nxt;
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, st_nxt.alarm_minute, st_nxt.alarm_hour, st_nxt.year,
                     st_nxt.month, st_nxt.date, st_nxt.minute, st_nxt.hour,
                     rtc_write, alarm_hit, st_nxt.armed, st_nxt.edit, st_nxt.view};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/cas_checker.sv =====
// port level checks for the clock and alarm set controller, bound to the top level
`timescale 1ns / 1ps
module cas_checker
  import cas_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // an rtc write request only comes with leaving edit mode
  a_wr_not_editing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[4:2] == EDIT_NONE)
    else $error("rtc write while still editing");

  // the buzzer only sounds on an armed alarm whose time matches
  a_hit_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |->
      out_tdata[5] && out_tdata[12:8] == out_tdata[39:35] &&
      out_tdata[18:13] == out_tdata[45:40])
    else $error("alarm hit without armed matching alarm");

  // input is accepted whenever the result drains, so no bubble is forced
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready)
    else $error("input blocked although output drains");

  // the result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind clock_alarm_set_controller cas_checker u_cas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/cas_scoreboard_pkg.sv =====
// result tracking and prediction for the clock and alarm set controller testbench
`timescale 1ns / 1ps
package cas_scoreboard_pkg;
  import cas_pkg::*;

  // out_tdata layout, highest field first
  typedef struct packed {
    logic [1:0] pad;
    logic [5:0] alarm_minute;
    logic [4:0] alarm_hour;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [5:0] minute;
    logic [4:0] hour;
    logic       rtc_write;
    logic       alarm_hit;
    logic       alarm_on;
    logic [2:0] edit;
    logic [1:0] view;
  } clock_status_t;

  class cas_scoreboard;
    view_t      view;
    logic [2:0] edit;
    logic       armed;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;

    clock_status_t expected_status[$];
    int errors;
    int n_events;
    int n_checked;
    int n_writes;
    int n_hits;
    int n_loads;

    function new();
      view         = VIEW_TIME;
      edit         = EDIT_NONE;
      armed        = 1'b0;
      hour         = 5'd11;
      minute       = 6'd50;
      date         = 5'd25;
      month        = 4'd12;
      year         = 7'd21;
      alarm_hour   = 5'd0;
      alarm_minute = 6'd0;
      errors       = 0;
      n_events     = 0;
      n_checked    = 0;
      n_writes     = 0;
      n_hits       = 0;
      n_loads      = 0;
    endfunction

    function int month_days(logic [3:0] m, logic [6:0] y);
      case (m)
        4'd4, 4'd6, 4'd9, 4'd11: return 30;
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
        default: return (y[1:0] == 2'b00) ? 29 : 28;
      endcase
    endfunction

    function int step_wrap(int v, int top, int low);
      int n;
      n = v + 1;
      if (n > top) n = low;
      return n;
    endfunction

    function int bcd_value(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // advance the predicted clock state by one accepted event
    function void note_event(action_t act, cas_bcd_t b);
      clock_status_t s;
      logic          wr;
      wr = 1'b0;
      case (act)
        ACT_MODE: begin
          if (edit == EDIT_NONE) begin
            view = view_t'(view + 2'd1);
          end else begin
            if (view == VIEW_TIME || view == VIEW_DATE) wr = 1'b1;
            else if (view == VIEW_ALARM) armed = 1'b1;
            edit = EDIT_NONE;
          end
        end
        ACT_SET: begin
          case (view)
            VIEW_TIME: edit = (int'(edit) + 1 > int'(TIME_LAST)) ? EDIT_NONE : edit + 3'd1;
            VIEW_DATE: edit = (int'(edit) + 1 > int'(DATE_LAST)) ? EDIT_NONE : edit + 3'd1;
            VIEW_ALARM: begin
              if (int'(edit) + 1 > int'(ALARM_LAST)) begin
                // stepping past the last alarm field wipes the alarm
                edit         = EDIT_NONE;
                alarm_hour   = 5'd0;
                alarm_minute = 6'd0;
                armed        = 1'b0;
              end else begin
                edit = edit + 3'd1;
              end
            end
            default: ;
          endcase
        end
        ACT_INC: begin
          if (edit == EDIT_NONE) begin
            armed = 1'b0;
          end else if (view == VIEW_TIME || view == VIEW_DATE) begin
            if (edit == EDIT_1)
              date = 5'(step_wrap(date, month_days(month, year), 1));
            else if (edit == EDIT_2)
              month = 4'(step_wrap(month, 12, 1));
            else if (edit == EDIT_3 && view == VIEW_TIME)
              hour = 5'(step_wrap(hour, 23, 0));
            else if (edit == EDIT_4 && view == VIEW_TIME)
              minute = 6'(step_wrap(minute, 59, 0));
            else if (edit == EDIT_3 && view == VIEW_DATE)
              year = 7'(step_wrap(year, 99, 0));
          end else if (view == VIEW_ALARM) begin
            if (edit == EDIT_1) alarm_hour = 5'(step_wrap(alarm_hour, 23, 0));
            else if (edit == EDIT_2) alarm_minute = 6'(step_wrap(alarm_minute, 59, 0));
          end
        end
        default: begin
          if (edit == EDIT_NONE) begin
            minute = 6'(bcd_value(b.minute));
            hour   = 5'(bcd_value({2'b00, b.hour[5:0]}));
            date   = 5'(bcd_value(b.date));
            month  = 4'(bcd_value(b.month));
            year   = 7'(bcd_value(b.year));
            n_loads++;
          end
        end
      endcase

      s.pad          = 2'b00;
      s.view         = view;
      s.edit         = edit;
      s.alarm_on     = armed;
      s.alarm_hit    = armed && hour == alarm_hour && minute == alarm_minute;
      s.rtc_write    = wr;
      s.hour         = hour;
      s.minute       = minute;
      s.date         = date;
      s.month        = month;
      s.year         = year;
      s.alarm_hour   = alarm_hour;
      s.alarm_minute = alarm_minute;
      if (wr) n_writes++;
      if (s.alarm_hit) n_hits++;
      n_events++;
      expected_status.push_back(s);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_status(logic [47:0] d);
      clock_status_t e;
      clock_status_t a;
      a = clock_status_t'(d);
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, d);
        errors++;
        return;
      end
      e = expected_status.pop_front();
      n_checked++;
      compare_field("view", e.view, a.view);
      compare_field("edit_field", e.edit, a.edit);
      compare_field("alarm_on", e.alarm_on, a.alarm_on);
      compare_field("alarm_hit", e.alarm_hit, a.alarm_hit);
      compare_field("rtc_write", e.rtc_write, a.rtc_write);
      compare_field("hour_now", e.hour, a.hour);
      compare_field("minute_now", e.minute, a.minute);
      compare_field("date_now", e.date, a.date);
      compare_field("month_now", e.month, a.month);
      compare_field("year_now", e.year, a.year);
      compare_field("alarm_hour_now", e.alarm_hour, a.alarm_hour);
      compare_field("alarm_minute_now", e.alarm_minute, a.alarm_minute);
      compare_field("pad bits", e.pad, a.pad);
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// top-level testbench for the clock, calendar and alarm set controller
`timescale 1ns / 1ps
module tb_top;
  import cas_pkg::*;
  import cas_scoreboard_pkg::*;

  localparam int RANDOM_EVENTS  = 450;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = 2'b00;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  cas_scoreboard sb;
  bit            quiet = 1'b0;
  int            n_sent = 0;
  int            idle_cycles = 0;

  clock_alarm_set_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check accepted transactions, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
    out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] to_bcd(int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // valid stays high across back-to-back transactions, lowered only for a gap
  task automatic send_event(action_t act, logic [IN_DATA_W-1:0] d);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 15) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_event(act, cas_bcd_t'(d));
    n_sent++;
  endtask

  task automatic press(action_t act);
    send_event(act, {8'($urandom), 32'($urandom)});
  endtask

  task automatic load_rtc(logic [7:0] mi, logic [7:0] hr, logic [7:0] dt,
                          logic [7:0] mo, logic [7:0] yr);
    send_event(ACT_LOAD, {yr, mo, dt, hr, mi});
  endtask

  task automatic goto_view(view_t v);
    if (sb.edit != EDIT_NONE) press(ACT_MODE);
    while (sb.view != v) press(ACT_MODE);
  endtask

  task automatic random_load();
    logic [7:0] hr;
    logic [7:0] dt;
    if ($urandom_range(0, 99) < 25) begin
      send_event(ACT_LOAD, {8'($urandom), 32'($urandom)});
    end else begin
      hr = to_bcd($urandom_range(0, 23));
      hr[7:6] = 2'($urandom);
      dt = ($urandom_range(0, 1) == 0) ? to_bcd($urandom_range(28, 31))
                                       : to_bcd($urandom_range(1, 31));
      load_rtc(to_bcd($urandom_range(0, 59)), hr, dt, to_bcd($urandom_range(1, 12)),
               to_bcd($urandom_range(0, 99)));
    end
  endtask

  // enter a view, step to a field, bump it and leave edit one way or another
  task automatic edit_session();
    view_t v;
    int    last;
    int    k;
    int    n;
    case ($urandom_range(0, 2))
      0: v = VIEW_TIME;
      1: v = VIEW_DATE;
      default: v = VIEW_ALARM;
    endcase
    goto_view(v);
    last = (v == VIEW_TIME) ? 4 : (v == VIEW_DATE) ? 3 : 2;
    k = $urandom_range(1, last);
    repeat (k) press(ACT_SET);
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 64) : $urandom_range(1, 5);
    repeat (n) press(ACT_INC);
    if ($urandom_range(0, 99) < 10) random_load();
    if ($urandom_range(0, 99) < 65) press(ACT_MODE);
    else repeat (last - k + 1) press(ACT_SET);
  endtask

  // arm the alarm if needed and bring the clock onto the alarm time, sometimes disarming it with an increment
  task automatic alarm_match();
    if (sb.edit != EDIT_NONE) press(ACT_MODE);
    if (!sb.armed) begin
      goto_view(VIEW_ALARM);
      press(ACT_SET);
      repeat ($urandom_range(0, 3)) press(ACT_INC);
      press(ACT_SET);
      repeat ($urandom_range(0, 3)) press(ACT_INC);
      press(ACT_MODE);
    end
    load_rtc(to_bcd(int'(sb.alarm_minute)), to_bcd(int'(sb.alarm_hour)),
             to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(1, 12)),
             to_bcd($urandom_range(0, 99)));
    if ($urandom_range(0, 1) == 0) press(ACT_INC);
  endtask

  initial begin
    int r;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bcd extremes, including invalid digits
    load_rtc(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    load_rtc(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    load_rtc(8'h59, 8'h23, 8'h31, 8'h12, 8'h99);
    // every time field wraps at its top, then leave by stepping past the last
    press(ACT_SET);
    press(ACT_INC);
    press(ACT_SET);
    press(ACT_INC);
    press(ACT_SET);
    press(ACT_INC);
    press(ACT_SET);
    press(ACT_INC);
    press(ACT_SET);
    press(ACT_SET);
    press(ACT_MODE);
    // year wrap in the date view
    press(ACT_MODE);
    press(ACT_SET);
    press(ACT_SET);
    press(ACT_SET);
    press(ACT_INC);
    press(ACT_MODE);
    // lunar view ignores set, then arm the alarm at the current time
    press(ACT_MODE);
    press(ACT_SET);
    press(ACT_MODE);
    press(ACT_SET);
    press(ACT_MODE);
    press(ACT_INC);
    press(ACT_SET);
    press(ACT_SET);
    press(ACT_SET);

    while (n_sent < RANDOM_EVENTS) begin
      quiet = (n_sent >= 200 && n_sent < 300);
      r = $urandom_range(0, 99);
      if (r < 45) edit_session();
      else if (r < 60) random_load();
      else if (r < 70) alarm_match();
      else press(action_t'($urandom_range(0, 3)));
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d events (%0d rtc loads) and checked %0d results",
             sb.n_events, sb.n_loads, sb.n_checked);
    $display("saw %0d rtc write requests and %0d alarm hits, %0d mismatches",
             sb.n_writes, sb.n_hits, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
